// ----- rtl/core/tlik_pkg.sv -----
// ----------------------------------------------------------------------------
// tlik_pkg: shared types and constants
// Widths, fixed-point constants and the CORDIC arctangent table for the
// two-link inverse kinematics pipeline.
// ----------------------------------------------------------------------------
package tlik_pkg;

  localparam int AngleFracBits = 4;
  localparam int CordicStages  = 16;
  localparam int TableLen      = 24;
  localparam int NumCordic     = (CordicStages > TableLen) ? TableLen : CordicStages;
  localparam int DegShift      = 24;
  localparam int RoundShift    = DegShift - AngleFracBits;

  localparam int RadW  = 20;
  localparam int RootW = 26;
  localparam int RemW  = 27;
  localparam int LimW  = 18;
  localparam int XW    = 30;
  localparam int ZW    = 34;
  localparam int SqrtSteps = RootW;

  localparam logic signed [ZW-1:0] Deg90  = ZW'(longint'(90) << DegShift);
  localparam logic signed [ZW-1:0] Deg180 = ZW'(longint'(180) << DegShift);
  localparam logic signed [ZW-1:0] RoundHalf = ZW'(longint'(1) << (RoundShift - 1));
  localparam logic [13:0] Deg270Out = 14'(270 * (2 ** AngleFracBits));

  typedef struct packed {
    logic                   valid;
    logic                   reach;
    logic [RadW-1:0]        pend_h;
    logic [RadW-1:0]        pend_s;
    logic [RemW-1:0]        rem_h;
    logic [RootW-1:0]       root_h;
    logic [RemW-1:0]        rem_s;
    logic [RootW-1:0]       root_s;
    logic signed [10:0]     xb;
    logic signed [10:0]     yb;
    logic signed [ZW-1:0]   zb;
  } sq_t;

  typedef struct packed {
    logic                   valid;
    logic                   reach;
    logic signed [XW-1:0]   ax;
    logic signed [XW-1:0]   ay;
    logic signed [ZW-1:0]   az;
    logic signed [XW-1:0]   bx;
    logic signed [XW-1:0]   by;
    logic signed [ZW-1:0]   bz;
  } cd_t;

  function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = 34'sd754974720;
      5'd1:  v = 34'sd445687602;
      5'd2:  v = 34'sd235489088;
      5'd3:  v = 34'sd119537938;
      5'd4:  v = 34'sd60000934;
      5'd5:  v = 34'sd30029717;
      5'd6:  v = 34'sd15018523;
      5'd7:  v = 34'sd7509720;
      5'd8:  v = 34'sd3754917;
      5'd9:  v = 34'sd1877466;
      5'd10: v = 34'sd938734;
      5'd11: v = 34'sd469367;
      5'd12: v = 34'sd234684;
      5'd13: v = 34'sd117342;
      5'd14: v = 34'sd58671;
      5'd15: v = 34'sd29335;
      5'd16: v = 34'sd14668;
      5'd17: v = 34'sd7334;
      5'd18: v = 34'sd3667;
      5'd19: v = 34'sd1833;
      5'd20: v = 34'sd917;
      5'd21: v = 34'sd458;
      5'd22: v = 34'sd229;
      5'd23: v = 34'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/tlik_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// tlik_sqrt_cell: one digit of the square root chain
// Produces one root bit for the reach lane and the side lane and passes the
// remaining operands to the next cell.
// ----------------------------------------------------------------------------
module tlik_sqrt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  tlik_pkg::sq_t d_i,
  output tlik_pkg::sq_t q_o
);
  import tlik_pkg::*;

  sq_t             cell_d, cell_q;
  logic [RemW+1:0] acc_h, acc_s, trial_h, trial_s;

  always_comb begin
    cell_d = d_i;
    acc_h   = {d_i.rem_h, d_i.pend_h[RadW-1 -: 2]};
    acc_s   = {d_i.rem_s, d_i.pend_s[RadW-1 -: 2]};
    trial_h = {1'b0, d_i.root_h, 2'b01};
    trial_s = {1'b0, d_i.root_s, 2'b01};
    cell_d.pend_h = {d_i.pend_h[RadW-3:0], 2'b00};
    cell_d.pend_s = {d_i.pend_s[RadW-3:0], 2'b00};
    if (acc_h >= trial_h) begin
      cell_d.rem_h  = RemW'(acc_h - trial_h);
      cell_d.root_h = {d_i.root_h[RootW-2:0], 1'b1};
    end else begin
      cell_d.rem_h  = acc_h[RemW-1:0];
      cell_d.root_h = {d_i.root_h[RootW-2:0], 1'b0};
    end
    if (acc_s >= trial_s) begin
      cell_d.rem_s  = RemW'(acc_s - trial_s);
      cell_d.root_s = {d_i.root_s[RootW-2:0], 1'b1};
    end else begin
      cell_d.rem_s  = acc_s[RemW-1:0];
      cell_d.root_s = {d_i.root_s[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

// ----- rtl/core/tlik_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// tlik_cordic_cell: one vectoring CORDIC iteration for two lanes
// Rotates the alpha lane and the direction lane by one table angle each.
// ----------------------------------------------------------------------------
module tlik_cordic_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic [4:0]                     shift_i,
  input  logic signed [tlik_pkg::ZW-1:0] angle_i,
  input  tlik_pkg::cd_t                  d_i,
  output tlik_pkg::cd_t                  q_o
);
  import tlik_pkg::*;

  cd_t                cell_d, cell_q;
  logic signed [XW-1:0] adx, ady, bdx, bdy;

  always_comb begin
    cell_d = d_i;
    adx = d_i.ay >>> shift_i;
    ady = d_i.ax >>> shift_i;
    bdx = d_i.by >>> shift_i;
    bdy = d_i.bx >>> shift_i;
    if (d_i.ay > 0) begin
      cell_d.ax = d_i.ax + adx;
      cell_d.ay = d_i.ay - ady;
      cell_d.az = d_i.az + angle_i;
    end else begin
      cell_d.ax = d_i.ax - adx;
      cell_d.ay = d_i.ay + ady;
      cell_d.az = d_i.az - angle_i;
    end
    if (d_i.by > 0) begin
      cell_d.bx = d_i.bx + bdx;
      cell_d.by = d_i.by - bdy;
      cell_d.bz = d_i.bz + angle_i;
    end else begin
      cell_d.bx = d_i.bx - bdx;
      cell_d.by = d_i.by + bdy;
      cell_d.bz = d_i.bz - angle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

// ----- rtl/core/two_link_arm_inverse_kinematics.sv -----
// ----------------------------------------------------------------------------
// two_link_arm_inverse_kinematics: joint angles for a two-link planar arm
// Squares the target, takes two square roots in a digit chain, runs two
// vectoring CORDIC chains and forms shoulder, elbow and wrist angles.
//
//   Channel  Direction  Payload
//   s_axis   in         tdata: target_x, target_y
//   m_axis   out        tdata: shoulder, elbow, wrist; tuser: reachable
//   cfg      in         link_length
//
// One request is taken per cycle while the skid register is empty; a result
// passes 2 front stages, 26 root cells, 16 CORDIC cells, 1 angle stage and
// the output register. Reset clears all stage valid bits and sets the link
// length to 10. The whole chain holds only when the skid register is full.
// ----------------------------------------------------------------------------
module two_link_arm_inverse_kinematics (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // target_x, target_y
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // shoulder_angle, elbow_angle, wrist_angle
  output logic        m_axis_tuser_o    // reachable
);
  import tlik_pkg::*;

  typedef struct packed {
    logic             valid;
    logic [RadW-1:0]  r2;
    logic signed [10:0] xb;
    logic signed [10:0] yb;
    logic signed [ZW-1:0] zb;
  } f0_t;

  typedef struct packed {
    logic                 valid;
    logic                 reach;
    logic signed [ZW-1:0] sh_raw;
    logic signed [ZW-1:0] el_raw;
  } f2_t;

  logic [LimW-1:0] lim_q;
  f0_t             f0_d, f0_q;
  sq_t             f1_d;
  sq_t             sq_s [0:SqrtSteps];
  cd_t             cd_s [0:NumCordic];
  f2_t             f2_d, f2_q;
  logic            en;
  logic signed [9:0]  tx, ty;
  logic signed [10:0] xe, ye;
  logic signed [ZW-1:0] alpha;
  logic signed [ZW-1:0] sh_sum, el_sum;
  logic [13:0]     sh_w, wr_w;
  logic [11:0]     el_w;
  logic [40:0]     res_w;
  logic [40:0]     out_q, skid_q;
  logic            out_v_q, skid_v_q;
  logic            pop, push;

  assign en = !skid_v_q;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= LimW'(400);
    end else if (cfg_we_i) begin
      lim_q <= LimW'({cfg_wdata_i, 2'b00} * cfg_wdata_i);
    end
  end

  always_comb begin
    tx = $signed(s_axis_tdata_i[9:0]);
    ty = $signed(s_axis_tdata_i[19:10]);
    xe = 11'(tx);
    ye = 11'(ty);
    f0_d.valid = s_axis_tvalid_i;
    f0_d.r2 = RadW'(xe) * RadW'(xe) + RadW'(ye) * RadW'(ye);
    if (tx < 0) begin
      if (ty >= 0) begin
        f0_d.xb = ye;
        f0_d.yb = -xe;
        f0_d.zb = Deg90;
      end else begin
        f0_d.xb = -ye;
        f0_d.yb = xe;
        f0_d.zb = -Deg90;
      end
    end else begin
      f0_d.xb = xe;
      f0_d.yb = ye;
      f0_d.zb = '0;
    end
  end

  always_comb begin
    f1_d = '0;
    f1_d.valid  = f0_q.valid;
    f1_d.reach  = (f0_q.r2 != '0) && (f0_q.r2 <= RadW'(lim_q));
    f1_d.pend_h = f0_q.r2;
    f1_d.pend_s = f1_d.reach ? RadW'(RadW'(lim_q) - f0_q.r2) : '0;
    f1_d.xb     = f0_q.xb;
    f1_d.yb     = f0_q.yb;
    f1_d.zb     = f0_q.zb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_q     <= '0;
      sq_s[0]  <= '0;
    end else if (en) begin
      f0_q     <= f0_d;
      sq_s[0]  <= f1_d;
    end
  end

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    tlik_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .d_i    (sq_s[i]),
      .q_o    (sq_s[i+1])
    );
  end

  always_comb begin
    cd_s[0].valid = sq_s[SqrtSteps].valid;
    cd_s[0].reach = sq_s[SqrtSteps].reach;
    cd_s[0].ax    = $signed(XW'(sq_s[SqrtSteps].root_h));
    cd_s[0].ay    = $signed(XW'(sq_s[SqrtSteps].root_s));
    cd_s[0].az    = '0;
    cd_s[0].bx    = $signed({{3{sq_s[SqrtSteps].xb[10]}}, sq_s[SqrtSteps].xb, 16'b0});
    cd_s[0].by    = $signed({{3{sq_s[SqrtSteps].yb[10]}}, sq_s[SqrtSteps].yb, 16'b0});
    cd_s[0].bz    = sq_s[SqrtSteps].zb;
  end

  for (genvar i = 0; i < NumCordic; i++) begin : g_cordic
    tlik_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .shift_i (5'(i)),
      .angle_i (atan_deg(5'(i))),
      .d_i     (cd_s[i]),
      .q_o     (cd_s[i+1])
    );
  end

  always_comb begin
    alpha = cd_s[NumCordic].az;
    if (alpha < 0) begin
      alpha = '0;
    end else if (alpha > Deg90) begin
      alpha = Deg90;
    end
    f2_d.valid  = cd_s[NumCordic].valid;
    f2_d.reach  = cd_s[NumCordic].reach;
    f2_d.sh_raw = cd_s[NumCordic].bz + alpha;
    f2_d.el_raw = Deg180 - (alpha <<< 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_q <= '0;
    end else if (en) begin
      f2_q <= f2_d;
    end
  end

  always_comb begin
    sh_sum = (f2_q.sh_raw + RoundHalf) >>> RoundShift;
    el_sum = (f2_q.el_raw + RoundHalf) >>> RoundShift;
    sh_w   = sh_sum[13:0];
    el_w   = el_sum[11:0];
    wr_w   = Deg270Out - sh_w - {2'b00, el_w};
    if (f2_q.reach) begin
      res_w = {1'b1, wr_w, el_w, sh_w};
    end else begin
      res_w = '0;
    end
  end

  assign pop  = out_v_q && m_axis_tready_i;
  assign push = en && f2_q.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        skid_v_q <= 1'b0;
      end
    end else if (push) begin
      if (out_v_q && !pop) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_v_q && !pop) begin
        skid_q <= res_w;
      end else begin
        out_q <= res_w;
      end
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q[39:0];
  assign m_axis_tuser_o  = out_q[40];

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds a result while the output is empty");

  a_unreach_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("unreachable result carries nonzero angles");

  a_elbow_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o[25:14] <= 12'd2880))
    else $error("elbow angle out of range");

endmodule
